>>> rtl/bprm_pkg.sv
// Shared types, widths and constants for the RMS/peak/crest/transient meter.
// No dependencies; used by all rtl modules through scoped names.
package bprm_pkg;

   localparam int NUM_LANES   = 8;
   localparam int SMP_W       = 16;
   localparam int SUM_W       = 19;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 26;
   localparam int MONO_W      = 17;
   localparam int PEAK_W      = 17;
   localparam int SS_W        = 47;
   localparam int FRAME_W     = 17;
   localparam int TC_W        = 16;
   localparam int LOG_W       = 26;
   localparam int LOG_FRAC_W  = 20;
   localparam int LQ_W        = 28;
   localparam int DB_W        = 17;
   localparam int CREST_W     = 16;
   localparam int DENS_W      = 17;
   localparam int DIV_NUM_W   = 32;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 72;
   localparam int CSR_DATA_W  = 16;

   localparam logic [FRAME_W-1:0] MAX_FRAMES    = 17'd65536;
   localparam logic [TC_W-1:0]    MAX_TRANS     = 16'd65535;
   localparam logic [SS_W-1:0]    SS_LIMIT      = {SS_W{1'b1}};
   localparam logic [25:0]        DB_PER_OCT    = 26'd50504453;
   localparam logic [DB_W-1:0]    DB_FLOOR_MAG  = 17'd61440;
   localparam logic [DENS_W-1:0]  DENS_MAX      = 17'd65536;

   localparam logic [0:0] REG_CHANNEL_COUNT = 1'd0;
   localparam logic [0:0] REG_THRESHOLD     = 1'd1;

   localparam logic [1:0] LOG_SEL_SS = 2'd0;
   localparam logic [1:0] LOG_SEL_FC = 2'd1;
   localparam logic [1:0] LOG_SEL_PK = 2'd2;

   localparam logic DB_SEL_RMS  = 1'b0;
   localparam logic DB_SEL_PEAK = 1'b1;

   typedef struct packed {
      logic       load;
      logic       sum;
      logic       mono;
      logic       acc;
      logic       log_start;
      logic [1:0] log_sel;
      logic       log_cap;
      logic       div_start;
      logic       db_mult;
      logic       db_sel;
      logic       db_cap;
      logic       out_write;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic log_done;
      logic div_idle;
      logic out_free;
   } dp_sts_type;

   // ceil(2^26 / d) for truncating division of the lane sum
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         4'd2:    r = 27'd33554432;
         4'd3:    r = 27'd22369622;
         4'd4:    r = 27'd16777216;
         4'd5:    r = 27'd13421773;
         4'd6:    r = 27'd11184811;
         4'd7:    r = 27'd9586981;
         4'd8:    r = 27'd8388608;
         default: r = 27'd67108864;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/bprm_log2.sv
// Iterative log2 unit: shift normalization, then 20 squaring rounds.
// Depends on bprm_pkg.
module bprm_log2 (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bprm_pkg::SS_W-1:0]    x,
   output logic                         done,
   output logic [bprm_pkg::LOG_W-1:0]   result
);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_NORM = 2'd1;
   localparam logic [1:0] L_SQ   = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [bprm_pkg::SS_W-1:0] norm_ff, norm_in;
   logic [5:0]  exp_ff, exp_in;
   logic [30:0] m_ff, m_in;
   logic [bprm_pkg::LOG_FRAC_W-1:0] frac_ff, frac_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [61:0] sq;
   logic [31:0] sq_hi;

   assign sq    = 62'(m_ff) * 62'(m_ff);
   assign sq_hi = sq[61:30];

   always_comb begin
      state_in = state_ff;
      norm_in  = norm_ff;
      exp_in   = exp_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               norm_in = x;
               exp_in  = 6'd46;
               frac_in = '0;
               cnt_in  = '0;
               if (x == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = L_NORM;
               end
            end
         end
         L_NORM: begin
            if (norm_ff[bprm_pkg::SS_W-1]) begin
               m_in     = norm_ff[bprm_pkg::SS_W-1 -: 31];
               state_in = L_SQ;
            end else begin
               norm_in = {norm_ff[bprm_pkg::SS_W-2:0], 1'b0};
               exp_in  = exp_ff - 6'd1;
            end
         end
         L_SQ: begin
            if (sq_hi[31]) begin
               m_in = sq_hi[31:1];
            end else begin
               m_in = sq_hi[30:0];
            end
            frac_in = {frac_ff[bprm_pkg::LOG_FRAC_W-2:0], sq_hi[31]};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(bprm_pkg::LOG_FRAC_W - 1)) begin
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      norm_ff <= norm_in;
      exp_ff  <= exp_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = {exp_ff, frac_ff};

endmodule

>>> rtl/bprm_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on bprm_pkg.
module bprm_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bprm_pkg::DIV_NUM_W-1:0]    num,
   input  logic [bprm_pkg::FRAME_W-1:0]      den,
   output logic                              busy,
   output logic [bprm_pkg::DIV_NUM_W-1:0]    quot
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [bprm_pkg::DIV_NUM_W-1:0] q_ff, q_in;
   logic [bprm_pkg::FRAME_W:0]     rem_ff, rem_in;
   logic [bprm_pkg::FRAME_W-1:0]   den_ff, den_in;
   logic [bprm_pkg::FRAME_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff[bprm_pkg::FRAME_W-1:0], q_ff[bprm_pkg::DIV_NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[bprm_pkg::DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[bprm_pkg::DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(bprm_pkg::DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

>>> rtl/bprm_ctrl.sv
// Sequencer for frame accumulation and end-of-block result computation.
// Depends on bprm_pkg.
module bprm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bprm_pkg::dp_sts_type  sts,
   output bprm_pkg::dp_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SUM  = 4'd1;
   localparam logic [3:0] S_MONO = 4'd2;
   localparam logic [3:0] S_ACC  = 4'd3;
   localparam logic [3:0] S_LS0  = 4'd4;
   localparam logic [3:0] S_LW0  = 4'd5;
   localparam logic [3:0] S_LS1  = 4'd6;
   localparam logic [3:0] S_LW1  = 4'd7;
   localparam logic [3:0] S_LS2  = 4'd8;
   localparam logic [3:0] S_LW2  = 4'd9;
   localparam logic [3:0] S_M0   = 4'd10;
   localparam logic [3:0] S_R0   = 4'd11;
   localparam logic [3:0] S_M1   = 4'd12;
   localparam logic [3:0] S_R1   = 4'd13;
   localparam logic [3:0] S_OUT  = 4'd14;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_MONO;
         end
         S_MONO: begin
            cmd.mono = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.last ? S_LS0 : S_IDLE;
         end
         S_LS0: begin
            cmd.log_start = 1'b1;
            cmd.log_sel   = bprm_pkg::LOG_SEL_SS;
            cmd.div_start = 1'b1;
            state_in      = S_LW0;
         end
         S_LW0: begin
            cmd.log_sel = bprm_pkg::LOG_SEL_SS;
            if (sts.log_done) begin
               cmd.log_cap = 1'b1;
               state_in    = S_LS1;
            end
         end
         S_LS1: begin
            cmd.log_start = 1'b1;
            cmd.log_sel   = bprm_pkg::LOG_SEL_FC;
            state_in      = S_LW1;
         end
         S_LW1: begin
            cmd.log_sel = bprm_pkg::LOG_SEL_FC;
            if (sts.log_done) begin
               cmd.log_cap = 1'b1;
               state_in    = S_LS2;
            end
         end
         S_LS2: begin
            cmd.log_start = 1'b1;
            cmd.log_sel   = bprm_pkg::LOG_SEL_PK;
            state_in      = S_LW2;
         end
         S_LW2: begin
            cmd.log_sel = bprm_pkg::LOG_SEL_PK;
            if (sts.log_done) begin
               cmd.log_cap = 1'b1;
               state_in    = S_M0;
            end
         end
         S_M0: begin
            cmd.db_mult = 1'b1;
            cmd.db_sel  = bprm_pkg::DB_SEL_RMS;
            state_in    = S_R0;
         end
         S_R0: begin
            cmd.db_cap = 1'b1;
            cmd.db_sel = bprm_pkg::DB_SEL_RMS;
            state_in   = S_M1;
         end
         S_M1: begin
            cmd.db_mult = 1'b1;
            cmd.db_sel  = bprm_pkg::DB_SEL_PEAK;
            state_in    = S_R1;
         end
         S_R1: begin
            cmd.db_cap = 1'b1;
            cmd.db_sel = bprm_pkg::DB_SEL_PEAK;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (sts.div_idle && sts.out_free) begin
               cmd.out_write = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/bprm_dp.sv
// Datapath: config registers, frame accumulators, dB conversion, result register.
// Depends on bprm_pkg, bprm_log2 and bprm_div.
module bprm_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bprm_pkg::dp_cmd_type                 cmd,
   output bprm_pkg::dp_sts_type                 sts,
   input  logic [bprm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 csr_valid,
   input  logic [0:0]                           csr_index,
   input  logic [bprm_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bprm_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [3:0]  cc_ff;
   logic [15:0] thr_ff;
   logic [3:0]  lanes;

   logic signed [bprm_pkg::SMP_W-1:0] smp_ff [bprm_pkg::NUM_LANES];
   logic                              last_ff;
   logic signed [bprm_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [bprm_pkg::PEAK_W-1:0]       peak_ff, peak_in;
   logic                              neg_ff;
   logic [bprm_pkg::SUM_W+bprm_pkg::RECIP_W-1:0] prod_ff;
   logic [bprm_pkg::SUM_W-1:0]        sum_abs;

   logic [bprm_pkg::MONO_W-1:0]        mono_mag;
   logic signed [bprm_pkg::MONO_W-1:0] mono;
   logic signed [bprm_pkg::MONO_W-1:0] prev_ff;
   logic                               has_prev_ff;
   logic [33:0]                        sq;
   logic [bprm_pkg::SS_W:0]            ss_sum;
   logic [bprm_pkg::SS_W-1:0]          ss_ff;
   logic signed [bprm_pkg::MONO_W:0]   step;
   logic [bprm_pkg::MONO_W:0]          step_abs;
   logic [bprm_pkg::TC_W-1:0]          tc_ff;
   logic [bprm_pkg::FRAME_W-1:0]       fc_ff;

   logic [bprm_pkg::SS_W-1:0]  log_x;
   logic                       log_done;
   logic [bprm_pkg::LOG_W-1:0] log_res;
   logic [bprm_pkg::LOG_W-1:0] lss_ff, lfc_ff, lpk_ff;
   logic                       div_busy;
   logic [bprm_pkg::DIV_NUM_W-1:0] quot;
   logic [bprm_pkg::FRAME_W-1:0]   den;

   logic signed [bprm_pkg::LQ_W-1:0] rms_lq, pk_lq, sel_lq;
   logic [bprm_pkg::LQ_W-2:0]        lq_mag;
   logic                             dbneg_ff;
   logic [52:0]                      dbprod_ff;
   logic [53:0]                      dbround;
   logic [17:0]                      dbr;
   logic signed [bprm_pkg::DB_W-1:0] dbval;
   logic signed [bprm_pkg::DB_W-1:0] rms_db_ff, pk_db_ff;
   logic signed [bprm_pkg::DB_W:0]   crest_full;
   logic [bprm_pkg::CREST_W-1:0]     crest;
   logic [bprm_pkg::DENS_W-1:0]      dens;

   logic                               rsp_valid_ff;
   logic [bprm_pkg::RSP_DATA_W-1:0]    rsp_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff  <= 4'd2;
         thr_ff <= 16'd2621;
      end else if (csr_valid) begin
         unique case (csr_index)
            bprm_pkg::REG_CHANNEL_COUNT: cc_ff  <= csr_data[3:0];
            bprm_pkg::REG_THRESHOLD:     thr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cc_ff == 4'd0) begin
         lanes = 4'd1;
      end else if (cc_ff > 4'(bprm_pkg::NUM_LANES)) begin
         lanes = 4'(bprm_pkg::NUM_LANES);
      end else begin
         lanes = cc_ff;
      end
   end

   // lane sum and peak
   always_comb begin
      logic [bprm_pkg::PEAK_W-1:0] a;
      sum_in = '0;
      peak_in = peak_ff;
      for (int i = 0; i < bprm_pkg::NUM_LANES; i++) begin
         a = smp_ff[i][bprm_pkg::SMP_W-1] ? 17'(-17'(smp_ff[i])) : 17'(smp_ff[i]);
         if (4'(i) < lanes) begin
            sum_in = sum_in + 19'(smp_ff[i]);
            if (a > peak_in) begin
               peak_in = a;
            end
         end
      end
   end

   assign sum_abs  = sum_ff[bprm_pkg::SUM_W-1] ? 19'(-sum_ff) : 19'(sum_ff);
   assign mono_mag = prod_ff[bprm_pkg::RECIP_SHIFT +: bprm_pkg::MONO_W];
   assign mono     = neg_ff ? -$signed(mono_mag) : $signed(mono_mag);
   assign sq       = 34'(mono_mag) * 34'(mono_mag);
   assign ss_sum   = 48'(ss_ff) + 48'(sq);
   assign step     = 18'(mono) - 18'(prev_ff);
   assign step_abs = step[bprm_pkg::MONO_W] ? 18'(-step) : 18'(step);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < bprm_pkg::NUM_LANES; i++) begin
            smp_ff[i] <= req_tdata[i*bprm_pkg::SMP_W +: bprm_pkg::SMP_W];
         end
         last_ff <= req_tlast;
      end
      if (cmd.sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.mono) begin
         neg_ff  <= sum_ff[bprm_pkg::SUM_W-1];
         prod_ff <= 46'(sum_abs) * 46'(bprm_pkg::recip(lanes));
      end
   end

   // block accumulators
   always_ff @(posedge clock) begin
      if (reset || cmd.out_write) begin
         ss_ff       <= '0;
         peak_ff     <= '0;
         prev_ff     <= '0;
         has_prev_ff <= 1'b0;
         tc_ff       <= '0;
         fc_ff       <= '0;
      end else begin
         if (cmd.sum) begin
            peak_ff <= peak_in;
         end
         if (cmd.acc) begin
            ss_ff <= (ss_sum > 48'(bprm_pkg::SS_LIMIT)) ? bprm_pkg::SS_LIMIT
                                                       : ss_sum[bprm_pkg::SS_W-1:0];
            if (has_prev_ff && (step_abs > 18'(thr_ff)) && (tc_ff < bprm_pkg::MAX_TRANS)) begin
               tc_ff <= tc_ff + 16'd1;
            end
            prev_ff     <= mono;
            has_prev_ff <= 1'b1;
            if (fc_ff < bprm_pkg::MAX_FRAMES) begin
               fc_ff <= fc_ff + 17'd1;
            end
         end
      end
   end

   // log2 and density division
   always_comb begin
      case (cmd.log_sel)
         bprm_pkg::LOG_SEL_FC: log_x = 47'(fc_ff);
         bprm_pkg::LOG_SEL_PK: log_x = 47'(peak_ff);
         default:              log_x = ss_ff;
      endcase
   end

   bprm_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   assign den = (fc_ff > 17'd1) ? (fc_ff - 17'd1) : 17'd1;

   bprm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({tc_ff, 16'd0}),
      .den   (den),
      .busy  (div_busy),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.log_cap) begin
         case (cmd.log_sel)
            bprm_pkg::LOG_SEL_FC: lfc_ff <= log_res;
            bprm_pkg::LOG_SEL_PK: lpk_ff <= log_res;
            default:              lss_ff <= log_res;
         endcase
      end
   end

   // dB conversion
   assign rms_lq = $signed({2'b00, lss_ff}) - $signed({2'b00, lfc_ff})
                 - $signed(28'(30 << bprm_pkg::LOG_FRAC_W));
   assign pk_lq  = ($signed({2'b00, lpk_ff}) - $signed(28'(15 << bprm_pkg::LOG_FRAC_W))) <<< 1;
   assign sel_lq = (cmd.db_sel == bprm_pkg::DB_SEL_PEAK) ? pk_lq : rms_lq;
   assign lq_mag = sel_lq[bprm_pkg::LQ_W-1] ? 27'(-sel_lq) : 27'(sel_lq);

   assign dbround = 54'(dbprod_ff) + 54'(64'd1 << 35);
   assign dbr     = dbround[53:36];

   always_comb begin
      if (!dbneg_ff) begin
         dbval = '0;
      end else if (dbr > 18'(bprm_pkg::DB_FLOOR_MAG)) begin
         dbval = -$signed(bprm_pkg::DB_FLOOR_MAG);
      end else begin
         dbval = -$signed(dbr[bprm_pkg::DB_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.db_mult) begin
         dbneg_ff  <= sel_lq[bprm_pkg::LQ_W-1];
         dbprod_ff <= 53'(lq_mag) * 53'(bprm_pkg::DB_PER_OCT);
      end
      if (cmd.db_cap) begin
         if (cmd.db_sel == bprm_pkg::DB_SEL_PEAK) begin
            pk_db_ff <= (peak_ff == '0) ? -$signed(bprm_pkg::DB_FLOOR_MAG) : dbval;
         end else begin
            rms_db_ff <= (ss_ff == '0) ? -$signed(bprm_pkg::DB_FLOOR_MAG) : dbval;
         end
      end
   end

   assign crest_full = 18'(pk_db_ff) - 18'(rms_db_ff);
   assign crest      = crest_full[bprm_pkg::DB_W] ? '0 : crest_full[bprm_pkg::CREST_W-1:0];
   assign dens       = (quot > 32'(bprm_pkg::DENS_MAX)) ? bprm_pkg::DENS_MAX
                                                        : quot[bprm_pkg::DENS_W-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_write) begin
         rsp_data_ff <= {5'd0, dens, crest, pk_db_ff, rms_db_ff};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign sts.last     = last_ff;
   assign sts.log_done = log_done;
   assign sts.div_idle = !div_busy;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

endmodule

>>> rtl/block_rms_peak_crest_transient_meter.sv
// Block RMS / peak / crest-factor / transient meter, top level.
// Depends on bprm_pkg, bprm_ctrl and bprm_dp.
//
// Each frame passes through the accumulation sequencer in turn (latch, lane sum,
// reciprocal multiply for the mono average, square-and-accumulate). A frame
// with tlast set adds end-of-block work: three log2 evaluations on the shared
// iterative log unit (shift normalization, then squaring rounds; a zero input
// skips both), dB conversion for RMS and then for peak, and one result write,
// which waits for the result register to be free and for the density division,
// which runs alongside the log2 work, to finish. Results sit in an output
// register, so the next block's frames are taken while a result waits.
module block_rms_peak_crest_transient_meter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample_ch0 .. sample_ch7, 16 bits each from bit 0 up
   input  logic [bprm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rms_level_db[16:0], peak_level_db[33:17], crest_db[49:34],
   // transient_density[66:50], zero pad
   output logic [bprm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [0:0]                           csr_index,
   input  logic [bprm_pkg::CSR_DATA_W-1:0]      csr_data
);

   bprm_pkg::dp_cmd_type cmd;
   bprm_pkg::dp_sts_type sts;

   assign csr_ready = 1'b1;

   bprm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bprm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/sv/tb_block_rms_peak_crest_transient_meter.sv
// Testbench for the block RMS / peak / crest / transient meter.
// Streams frames with random gaps, predicts each block result with its own level meter
// model and compares field by field. Depends on bprm_pkg and the rtl top level.
`timescale 1ns / 1ps

module tb_block_rms_peak_crest_transient_meter;

   typedef struct packed {
      logic       last;
      logic [127:0] samples;
   } frame_type;

   typedef struct packed {
      logic [16:0] dens;
      logic [15:0] crest;
      logic [16:0] peak_db;
      logic [16:0] rms_db;
   } level_type;

   localparam int LIMIT_CYCLES = 2000000;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tlast = 0, rsp_tready = 0, csr_valid = 0;
   logic [bprm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] csr_index = bprm_pkg::REG_CHANNEL_COUNT;
   logic [bprm_pkg::CSR_DATA_W-1:0] csr_data = '0;
   wire req_tready, rsp_tvalid, csr_ready;
   wire [bprm_pkg::RSP_DATA_W-1:0] rsp_tdata;

   block_rms_peak_crest_transient_meter uut (.*);

   initial forever #5 clock = ~clock;

   frame_type frame_q[$];
   level_type level_q[$];
   int failures = 0;
   int cycles = 0;

   // predictor state
   logic [3:0]  lane_cfg;
   logic [15:0] thresh_cfg;
   logic [46:0] sq_acc;
   int          pk_mag;
   int          prev_mono;
   bit          have_prev;
   int          trans_cnt;
   int          frames_seen;

   function automatic longint log2q20(longint unsigned x);
      int e;
      longint unsigned m;
      longint frac;
      e = 63;
      frac = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      for (int i = 0; i < 20; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m >>= 1;
            frac |= 64'sd1 << (19 - i);
         end
      end
      return (longint'(e) << 20) + frac;
   endfunction

   function automatic longint db256(longint lq);
      longint unsigned mag, r;
      longint v;
      mag = (lq < 0) ? -lq : lq;
      r = (mag * 64'd50504453 + (64'd1 << 35)) >> 36;
      v = (lq < 0) ? -longint'(r) : longint'(r);
      if (v < -61440) v = -61440;
      if (v > 0) v = 0;
      return v;
   endfunction

   task automatic clear_levels();
      sq_acc = '0; pk_mag = 0; prev_mono = 0; have_prev = 0;
      trans_cnt = 0; frames_seen = 0;
   endtask

   task automatic predict_frame(frame_type f);
      int lanes, sum, s, mono, stp;
      longint unsigned sq, lim;
      longint rdb, pdb, cr;
      longint unsigned den, dn;
      level_type lv;
      lanes = (lane_cfg < 1) ? 1 : (lane_cfg > 8 ? 8 : lane_cfg);
      sum = 0;
      for (int i = 0; i < lanes; i++) begin
         s = $signed(f.samples[i*16 +: 16]);
         sum += s;
         if ((s < 0 ? -s : s) > pk_mag) pk_mag = (s < 0 ? -s : s);
      end
      mono = sum / lanes;
      sq = longint'(mono) * mono;
      lim = (64'd1 << 47) - 1;
      sq_acc = (sq_acc > lim - sq) ? lim[46:0] : 47'(sq_acc + sq);
      if (have_prev) begin
         stp = mono - prev_mono;
         if (stp < 0) stp = -stp;
         if (stp > thresh_cfg && trans_cnt < 65535) trans_cnt++;
      end
      prev_mono = mono;
      have_prev = 1;
      if (frames_seen < 65536) frames_seen++;
      if (!f.last) return;
      rdb = (sq_acc == 0) ? -61440 :
            db256(log2q20(sq_acc) - log2q20(frames_seen) - (64'sd30 << 20));
      pdb = (pk_mag == 0) ? -61440 : db256(2 * (log2q20(pk_mag) - (64'sd15 << 20)));
      cr = pdb - rdb;
      if (cr < 0) cr = 0;
      if (cr > 65535) cr = 65535;
      dn = (frames_seen > 1) ? frames_seen - 1 : 1;
      den = (longint'(trans_cnt) << 16) / dn;
      if (den > 65536) den = 65536;
      lv.rms_db = rdb[16:0]; lv.peak_db = pdb[16:0];
      lv.crest = cr[15:0]; lv.dens = den[16:0];
      level_q.push_back(lv);
      clear_levels();
   endtask

   // handshake history for the falling-edge drivers
   bit req_fire = 0;
   bit rsp_fire = 0;
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
   end

   // driver
   int req_wait = 0;
   int rsp_wait = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (req_wait > 0) begin
               req_tvalid <= 0;
               req_wait = req_wait - 1;
            end else if (frame_q.size() > 0) begin
               req_tvalid <= 1;
               req_tdata <= frame_q[0].samples;
               req_tlast <= frame_q[0].last;
               frame_q.pop_front();
               req_wait = $urandom_range(0, 15);
            end else req_tvalid <= 0;
         end
         if (rsp_fire) rsp_wait = $urandom_range(0, 15);
         if (rsp_wait > 0) begin
            rsp_tready <= 0;
            rsp_wait = rsp_wait - 1;
         end else rsp_tready <= 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      level_type got, want;
      if (!reset) begin
         cycles <= cycles + 1;
         if (req_tvalid && req_tready) predict_frame({req_tlast, req_tdata});
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[66:0];
            if (level_q.size() == 0) begin
               $error("unexpected result transaction");
               failures++;
            end else begin
               want = level_q.pop_front();
               if (got.rms_db !== want.rms_db) begin
                  $error("rms_level_db exp %0d got %0d", $signed(want.rms_db), $signed(got.rms_db));
                  failures++;
               end
               if (got.peak_db !== want.peak_db) begin
                  $error("peak_level_db exp %0d got %0d", $signed(want.peak_db),
                         $signed(got.peak_db));
                  failures++;
               end
               if (got.crest !== want.crest) begin
                  $error("crest_db exp %0d got %0d", want.crest, got.crest);
                  failures++;
               end
               if (got.dens !== want.dens) begin
                  $error("transient_density exp %0d got %0d", want.dens, got.dens);
                  failures++;
               end
            end
         end
         if (cycles > LIMIT_CYCLES) begin
            $display("tb_block_rms_peak_crest_transient_meter NOT OK");
            $finish;
         end
      end
   end

   function automatic frame_type rand_frame(bit last, int style);
      frame_type f;
      for (int i = 0; i < 8; i++)
         case (style)
            0: f.samples[i*16 +: 16] = 16'($urandom);
            1: f.samples[i*16 +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: f.samples[i*16 +: 16] = 16'($urandom_range(0, 2047) - 1024);
         endcase
      f.last = last;
      return f;
   endfunction

   task automatic write_reg(logic [0:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == bprm_pkg::REG_CHANNEL_COUNT) lane_cfg = val[3:0]; else thresh_cfg = val;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (frame_q.size() > 0 || req_tvalid || level_q.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_block(int len, int style);
      for (int i = 0; i < len; i++) frame_q.push_back(rand_frame(i == len - 1, style));
   endtask

   initial begin
      frame_type f;
      int n;
      lane_cfg = 4'd2; thresh_cfg = 16'd2621;
      clear_levels();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, single-frame block, silence, saturation of levels
      f.samples = '0; f.last = 1; frame_q.push_back(f);
      f.samples = {8{16'h8000}}; f.last = 0; frame_q.push_back(f);
      f.samples = {8{16'h7fff}}; f.last = 0; frame_q.push_back(f);
      f.samples = {8{16'h8000}}; f.last = 1; frame_q.push_back(f);
      f.samples = {8{16'h0001}}; f.last = 1; frame_q.push_back(f);
      f.samples = {8{16'hffff}}; f.last = 0; frame_q.push_back(f);
      f.samples = '0; f.last = 1; frame_q.push_back(f);
      send_block(6, 1);
      drain();
      write_reg(bprm_pkg::REG_CHANNEL_COUNT, 16'd0);
      write_reg(bprm_pkg::REG_THRESHOLD, 16'd0);
      send_block(5, 1);
      send_block(4, 2);
      drain();
      write_reg(bprm_pkg::REG_CHANNEL_COUNT, 16'd15);
      write_reg(bprm_pkg::REG_THRESHOLD, 16'hffff);
      send_block(5, 0);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(bprm_pkg::REG_CHANNEL_COUNT,
                   (ph == 0) ? 16'd8 : (ph == 1 ? 16'd1 : 16'($urandom_range(0, 15))));
         write_reg(bprm_pkg::REG_THRESHOLD,
                   (ph == 2) ? 16'hffff : 16'($urandom_range(0, 6000)));
         n = 0;
         while (n < 120) begin
            int len, style;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            style = $urandom_range(0, 2);
            send_block(len, style);
            n += len;
         end
         drain();
      end

      if (failures == 0)
         $display("tb_block_rms_peak_crest_transient_meter OK");
      else
         $display("tb_block_rms_peak_crest_transient_meter NOT OK");
      $finish;
   end

endmodule

>>> sim.f
rtl/bprm_pkg.sv
rtl/bprm_log2.sv
rtl/bprm_div.sv
rtl/bprm_ctrl.sv
rtl/bprm_dp.sv
rtl/block_rms_peak_crest_transient_meter.sv
tb/sv/tb_block_rms_peak_crest_transient_meter.sv
